// ===== rtl/core/cpt_pkg.sv =====
// Package for the closest-point-on-triangle block: widths, payload and stage types,
// region codes and the coordinate difference helper.
// Depends on nothing; closest_point_on_triangle and cpt_div import it.
package cpt_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int EDGE_WIDTH    = COORD_WIDTH + 1;
   localparam int DOT_WIDTH     = 62;
   localparam int WIDE_WIDTH    = 128;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [EDGE_WIDTH-1:0]  edge_type;
   typedef logic signed [DOT_WIDTH-1:0]   dot_type;
   typedef logic signed [WIDE_WIDTH-1:0]  wide_type;

   typedef coord_type [2:0] cvec_type;
   typedef edge_type  [2:0] evec_type;
   typedef dot_type   [5:0] dvec_type;

   // Saturation bounds of a dot product and of an output coordinate.
   localparam dot_type   DOT_LIMIT = {1'b0, {(DOT_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      REGION_INTERIOR = 3'd0,
      REGION_A        = 3'd1,
      REGION_B        = 3'd2,
      REGION_C        = 3'd3,
      REGION_AB       = 3'd4,
      REGION_AC       = 3'd5,
      REGION_BC       = 3'd6
   } region_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type vertex_a_x;
      coord_type vertex_a_y;
      coord_type vertex_a_z;
      coord_type vertex_b_x;
      coord_type vertex_b_y;
      coord_type vertex_b_z;
      coord_type vertex_c_x;
      coord_type vertex_c_y;
      coord_type vertex_c_z;
   } req_type;

   typedef struct packed {
      coord_type  closest_x;
      coord_type  closest_y;
      coord_type  closest_z;
      logic [2:0] region;
      logic       degenerate;
   } rsp_type;

   // Triangle vertices and edges carried down the front of the pipeline.
   typedef struct packed {
      cvec_type a;
      cvec_type b;
      cvec_type c;
      evec_type ab;
      evec_type ac;
      evec_type bc;
   } geo_type;

   typedef struct packed {
      geo_type  geo;
      dvec_type d;
   } dots_type;

   // What the region decision hands to the back end beside the divider.
   typedef struct packed {
      region_type region;
      cvec_type   a;
      cvec_type   base;
      evec_type   e1;
      evec_type   e2;
   } pick_type;

   typedef struct packed {
      region_type region;
      logic       degenerate;
      cvec_type   base;
   } fin_type;

   // Exact difference of two coordinates.
   function automatic edge_type diff(coord_type x, coord_type y);
      return EDGE_WIDTH'(x) - EDGE_WIDTH'(y);
   endfunction

endpackage

// ===== rtl/core/closest_point_on_triangle.sv =====
// Throughput: one request per cycle; busy is never raised and results cannot be held off.
// The depth is set by the fraction divider, which resolves one quotient bit per stage.
// Reset (synchronous) clears the valid bits of every stage; data registers are not reset.
// Depends on cpt_pkg, cpt_mul, cpt_pipe and cpt_div.
module closest_point_on_triangle import cpt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int LAT  = 13 + FRAC_BITS;
   localparam int PW1  = 2 * EDGE_WIDTH;
   localparam int SW1  = PW1 + 2;
   localparam int SHW  = SW1 - FRAC_BITS;
   localparam int CMPW = (SHW > DOT_WIDTH + 1) ? SHW : DOT_WIDTH + 1;
   localparam int PW2  = 2 * DOT_WIDTH;
   localparam int TW   = FRAC_BITS + 2;
   localparam int PW3  = EDGE_WIDTH + TW;
   localparam int FW   = PW3 + 2;
   localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
   localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

   logic           accept;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   // Request register and the valid line that follows it down the pipeline.
   req_type req_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   // Edge and offset vectors.
   cvec_type p_v, a_v, b_v, c_v;
   geo_type  geo1_in, geo1_ff;
   evec_type ap_in, bp_in, cp_in, ap_ff, bp_ff, cp_ff;

   assign p_v = {req_ff.point_z, req_ff.point_y, req_ff.point_x};
   assign a_v = {req_ff.vertex_a_z, req_ff.vertex_a_y, req_ff.vertex_a_x};
   assign b_v = {req_ff.vertex_b_z, req_ff.vertex_b_y, req_ff.vertex_b_x};
   assign c_v = {req_ff.vertex_c_z, req_ff.vertex_c_y, req_ff.vertex_c_x};

   always_comb begin
      geo1_in.a = a_v;
      geo1_in.b = b_v;
      geo1_in.c = c_v;
      for (int k = 0; k < 3; k++) begin
         geo1_in.ab[k] = diff(b_v[k], a_v[k]);
         geo1_in.ac[k] = diff(c_v[k], a_v[k]);
         geo1_in.bc[k] = diff(c_v[k], b_v[k]);
         ap_in[k]      = diff(p_v[k], a_v[k]);
         bp_in[k]      = diff(p_v[k], b_v[k]);
         cp_in[k]      = diff(p_v[k], c_v[k]);
      end
   end

   always_ff @(posedge clock) begin
      geo1_ff <= geo1_in;
      ap_ff   <= ap_in;
      bp_ff   <= bp_in;
      cp_ff   <= cp_in;
   end

   // Products for the six dot products d1..d6.
   evec_type                e_src [2];
   evec_type                f_src [3];
   logic signed [PW1-1:0]   prod1 [6][3];
   geo_type                 geo3;

   assign e_src[0] = geo1_ff.ab;
   assign e_src[1] = geo1_ff.ac;
   assign f_src[0] = ap_ff;
   assign f_src[1] = bp_ff;
   assign f_src[2] = cp_ff;

   for (genvar j = 0; j < 6; j++) begin : g_dot
      for (genvar k = 0; k < 3; k++) begin : g_axis
         cpt_mul #(.AW(EDGE_WIDTH), .BW(EDGE_WIDTH)) u_mul (
            .clock (clock),
            .a     (e_src[j % 2][k]),
            .b     (f_src[j / 2][k]),
            .p     (prod1[j][k])
         );
      end
   end

   cpt_pipe #(.W($bits(geo_type)), .N(2)) u_geo_pipe (
      .clock (clock),
      .d     (geo1_ff),
      .q     (geo3)
   );

   // Sum, scale and saturate each dot product.
   logic signed [SW1-1:0]  dot_sum [6];
   logic signed [CMPW-1:0] dot_sh  [6];
   dots_type               dots4_in, dots4_ff;

   always_comb begin
      dots4_in.geo = geo3;
      for (int j = 0; j < 6; j++) begin
         dot_sum[j] = SW1'(prod1[j][0]) + SW1'(prod1[j][1]) + SW1'(prod1[j][2]);
         dot_sh[j]  = CMPW'(dot_sum[j] >>> FRAC_BITS);
         if (dot_sh[j] > CMPW'(DOT_LIMIT)) begin
            dots4_in.d[j] = DOT_LIMIT;
         end else if (dot_sh[j] < -CMPW'(DOT_LIMIT)) begin
            dots4_in.d[j] = -DOT_LIMIT;
         end else begin
            dots4_in.d[j] = DOT_WIDTH'(dot_sh[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      dots4_ff <= dots4_in;
   end

   // Cross products of dot products for va, vb and vc.
   logic signed [PW2-1:0] prod2 [6];
   dots_type              dots6;

   for (genvar m = 0; m < 6; m++) begin : g_cross
      cpt_mul #(.AW(DOT_WIDTH), .BW(DOT_WIDTH)) u_mul (
         .clock (clock),
         .a     (dots4_ff.d[MA[m]]),
         .b     (dots4_ff.d[MB[m]]),
         .p     (prod2[m])
      );
   end

   cpt_pipe #(.W($bits(dots_type)), .N(2)) u_dots_pipe (
      .clock (clock),
      .d     (dots4_ff),
      .q     (dots6)
   );

   wide_type va_ff, vb_ff, vc_ff;
   dots_type dots7_ff;

   always_ff @(posedge clock) begin
      vc_ff    <= WIDE_WIDTH'(prod2[0]) - WIDE_WIDTH'(prod2[1]);
      vb_ff    <= WIDE_WIDTH'(prod2[2]) - WIDE_WIDTH'(prod2[3]);
      va_ff    <= WIDE_WIDTH'(prod2[4]) - WIDE_WIDTH'(prod2[5]);
      dots7_ff <= dots6;
   end

   // Region decision, tested in the order a, b, c, ab, ac, bc, interior.
   dot_type                 d1, d2, d3, d4, d5, d6;
   logic signed [DOT_WIDTH:0]   d13, d26, d43, d56;
   logic signed [DOT_WIDTH+1:0] den6;
   wide_type                den_all;
   logic                    va_np, vb_np, vc_np;
   pick_type                pick_in, pick_ff;
   wide_type                num1_in, num2_in, den1_in, den2_in;
   wide_type                num1_ff, num2_ff, den1_ff, den2_ff;
   logic                    use1_in, use2_in, use1_ff, use2_ff;
   geo_type                 g7;

   assign g7 = dots7_ff.geo;
   assign d1 = dots7_ff.d[0];
   assign d2 = dots7_ff.d[1];
   assign d3 = dots7_ff.d[2];
   assign d4 = dots7_ff.d[3];
   assign d5 = dots7_ff.d[4];
   assign d6 = dots7_ff.d[5];

   always_comb begin
      d13     = (DOT_WIDTH+1)'(d1) - (DOT_WIDTH+1)'(d3);
      d26     = (DOT_WIDTH+1)'(d2) - (DOT_WIDTH+1)'(d6);
      d43     = (DOT_WIDTH+1)'(d4) - (DOT_WIDTH+1)'(d3);
      d56     = (DOT_WIDTH+1)'(d5) - (DOT_WIDTH+1)'(d6);
      den6    = (DOT_WIDTH+2)'(d43) + (DOT_WIDTH+2)'(d56);
      den_all = va_ff + vb_ff + vc_ff;
      va_np   = va_ff[WIDE_WIDTH-1] || (va_ff == '0);
      vb_np   = vb_ff[WIDE_WIDTH-1] || (vb_ff == '0);
      vc_np   = vc_ff[WIDE_WIDTH-1] || (vc_ff == '0);

      pick_in.region = REGION_INTERIOR;
      pick_in.a      = g7.a;
      pick_in.base   = g7.a;
      pick_in.e1     = g7.ab;
      pick_in.e2     = g7.ac;
      num1_in        = vb_ff;
      num2_in        = vc_ff;
      den1_in        = den_all;
      den2_in        = den_all;
      use1_in        = 1'b1;
      use2_in        = 1'b1;

      if (d1 <= 0 && d2 <= 0) begin
         pick_in.region = REGION_A;
         pick_in.e1     = '0;
         pick_in.e2     = '0;
         use1_in        = 1'b0;
         use2_in        = 1'b0;
      end else if (d3 >= 0 && d4 <= d3) begin
         pick_in.region = REGION_B;
         pick_in.base   = g7.b;
         pick_in.e1     = '0;
         pick_in.e2     = '0;
         use1_in        = 1'b0;
         use2_in        = 1'b0;
      end else if (d6 >= 0 && d5 <= d6) begin
         pick_in.region = REGION_C;
         pick_in.base   = g7.c;
         pick_in.e1     = '0;
         pick_in.e2     = '0;
         use1_in        = 1'b0;
         use2_in        = 1'b0;
      end else if (vc_np && d1 >= 0 && d3 <= 0) begin
         pick_in.region = REGION_AB;
         pick_in.e2     = '0;
         num1_in        = WIDE_WIDTH'(d1);
         den1_in        = WIDE_WIDTH'(d13);
         use2_in        = 1'b0;
      end else if (vb_np && d2 >= 0 && d6 <= 0) begin
         pick_in.region = REGION_AC;
         pick_in.e1     = g7.ac;
         pick_in.e2     = '0;
         num1_in        = WIDE_WIDTH'(d2);
         den1_in        = WIDE_WIDTH'(d26);
         use2_in        = 1'b0;
      end else if (va_np && d43 >= 0 && d56 >= 0) begin
         pick_in.region = REGION_BC;
         pick_in.base   = g7.b;
         pick_in.e1     = g7.bc;
         pick_in.e2     = '0;
         num1_in        = WIDE_WIDTH'(d43);
         den1_in        = WIDE_WIDTH'(den6);
         use2_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff <= pick_in;
      num1_ff <= num1_in;
      num2_ff <= num2_in;
      den1_ff <= den1_in;
      den2_ff <= den2_in;
      use1_ff <= use1_in;
      use2_ff <= use2_in;
   end

   // Interpolation fractions.
   logic [FRAC_BITS:0] q1, q2;
   logic               z1, z2;
   pick_type           pick_d;

   cpt_div #(.VW(WIDE_WIDTH), .FB(FRAC_BITS)) u_div1 (
      .clock (clock),
      .en    (use1_ff),
      .num   (num1_ff),
      .den   (den1_ff),
      .quo   (q1),
      .zero  (z1)
   );

   cpt_div #(.VW(WIDE_WIDTH), .FB(FRAC_BITS)) u_div2 (
      .clock (clock),
      .en    (use2_ff),
      .num   (num2_ff),
      .den   (den2_ff),
      .quo   (q2),
      .zero  (z2)
   );

   cpt_pipe #(.W($bits(pick_type)), .N(FRAC_BITS + 1)) u_pick_pipe (
      .clock (clock),
      .d     (pick_ff),
      .q     (pick_d)
   );

   // A zero divisor falls back to vertex a with zero weights.
   logic                  deg;
   logic [FRAC_BITS:0]    t1, t2;
   fin_type               fin_in, fin_d;
   logic signed [PW3-1:0] prod3a [3];
   logic signed [PW3-1:0] prod3b [3];

   always_comb begin
      deg               = z1 || z2;
      t1                = deg ? '0 : q1;
      t2                = deg ? '0 : q2;
      fin_in.region     = pick_d.region;
      fin_in.degenerate = deg;
      fin_in.base       = deg ? pick_d.a : pick_d.base;
   end

   for (genvar k = 0; k < 3; k++) begin : g_interp
      cpt_mul #(.AW(EDGE_WIDTH), .BW(TW)) u_mul1 (
         .clock (clock),
         .a     (pick_d.e1[k]),
         .b     ($signed({1'b0, t1})),
         .p     (prod3a[k])
      );
      cpt_mul #(.AW(EDGE_WIDTH), .BW(TW)) u_mul2 (
         .clock (clock),
         .a     (pick_d.e2[k]),
         .b     ($signed({1'b0, t2})),
         .p     (prod3b[k])
      );
   end

   cpt_pipe #(.W($bits(fin_type)), .N(2)) u_fin_pipe (
      .clock (clock),
      .d     (fin_in),
      .q     (fin_d)
   );

   // Offset from the base vertex, clamped to the coordinate range.
   logic signed [FW-1:0] off_sum [3];
   logic signed [FW-1:0] coord_sum [3];
   cvec_type             closest;
   rsp_type              rsp_in, rsp_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         off_sum[k]   = FW'(prod3a[k]) + FW'(prod3b[k]);
         coord_sum[k] = (off_sum[k] >>> FRAC_BITS) + FW'(fin_d.base[k]);
         if (coord_sum[k] > FW'(COORD_MAX)) begin
            closest[k] = COORD_MAX;
         end else if (coord_sum[k] < FW'(COORD_MIN)) begin
            closest[k] = COORD_MIN;
         end else begin
            closest[k] = COORD_WIDTH'(coord_sum[k]);
         end
      end
      rsp_in.closest_x  = closest[0];
      rsp_in.closest_y  = closest[1];
      rsp_in.closest_z  = closest[2];
      rsp_in.region     = fin_d.region;
      rsp_in.degenerate = fin_d.degenerate;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = vld_ff[LAT-1];

   // Every request produces exactly one result.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LAT) rsp_strobe)
      else $error("request did not produce a result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result without a request");

   // Vertex regions never divide, so they cannot report a degenerate triangle.
   a_vertex_not_degenerate: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.degenerate) |->
         (rsp_data.region != REGION_A && rsp_data.region != REGION_B &&
          rsp_data.region != REGION_C))
      else $error("degenerate flag on a vertex region");

endmodule

// ===== rtl/core/cpt_mul.sv =====
// Two-stage signed multiplier: four half-width partial products, then their sum.
// Standalone; no package needed.
module cpt_mul #(
   parameter int AW = 33,
   parameter int BW = 33
) (
   input  logic                    clock,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] p
);

   localparam int AL = AW / 2;
   localparam int AH = AW - AL;
   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW;

   logic signed [AH+BH-1:0] hh_ff;
   logic signed [AH+BL:0]   hl_ff;
   logic signed [AL+BH:0]   lh_ff;
   logic [AL+BL-1:0]        ll_ff;
   logic signed [PW-1:0]    p_ff;

   // Partial products: signed high halves, unsigned low halves.
   always_ff @(posedge clock) begin
      hh_ff <= $signed(a[AW-1:AL]) * $signed(b[BW-1:BL]);
      hl_ff <= $signed(a[AW-1:AL]) * $signed({1'b0, b[BL-1:0]});
      lh_ff <= $signed({1'b0, a[AL-1:0]}) * $signed(b[BW-1:BL]);
      ll_ff <= a[AL-1:0] * b[BL-1:0];
   end

   // Weighted sum of the partial products.
   always_ff @(posedge clock) begin
      p_ff <= (PW'(hh_ff) <<< (AL + BL)) + (PW'(hl_ff) <<< AL)
            + (PW'(lh_ff) <<< BL) + PW'(ll_ff);
   end

   assign p = p_ff;

endmodule

// ===== rtl/core/cpt_pipe.sv =====
// Fixed-length register delay line that keeps side data aligned with the datapath.
// Standalone; no package needed.
module cpt_pipe #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] stage_ff [N];

   // Shift the side data one stage per cycle.
   always_ff @(posedge clock) begin
      stage_ff[0] <= d;
      for (int i = 1; i < N; i++) begin
         stage_ff[i] <= stage_ff[i-1];
      end
   end

   assign q = stage_ff[N-1];

endmodule

// ===== rtl/core/cpt_div.sv =====
// Pipelined fraction unit: num/den clamped to [0, 1] with FB fraction bits,
// one quotient bit per stage. Depends on cpt_pkg.
module cpt_div import cpt_pkg::*; #(
   parameter int VW = WIDE_WIDTH,
   parameter int FB = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [VW-1:0] num,
   input  logic signed [VW-1:0] den,
   output logic [FB:0]          quo,
   output logic                 zero
);

   logic [VW-1:0] rem_ff  [FB+1];
   logic [VW-1:0] dvs_ff  [FB+1];
   logic [FB:0]   q_ff    [FB+1];
   logic          done_ff [FB+1];
   logic          zero_ff [FB+1];

   logic [VW-1:0] num_mag;
   logic [VW-1:0] den_mag;
   logic          den_zero;
   logic          skip;

   // Sign handling and the cases that need no division.
   always_comb begin
      den_zero = (den == '0);
      num_mag  = num[VW-1] ? VW'(-num) : VW'(num);
      den_mag  = den[VW-1] ? VW'(-den) : VW'(den);
      skip     = !en || den_zero || (num == '0) || (num[VW-1] != den[VW-1]);
   end

   always_ff @(posedge clock) begin
      zero_ff[0] <= en && den_zero;
      rem_ff[0]  <= num_mag;
      dvs_ff[0]  <= den_mag;
      if (skip) begin
         done_ff[0] <= 1'b1;
         q_ff[0]    <= '0;
      end else if (num_mag >= den_mag) begin
         done_ff[0] <= 1'b1;
         q_ff[0]    <= (FB+1)'(1) << FB;
      end else begin
         done_ff[0] <= 1'b0;
         q_ff[0]    <= '0;
      end
   end

   // Restoring division, one bit per stage.
   for (genvar i = 1; i <= FB; i++) begin : g_step
      logic [VW-1:0] shifted;
      assign shifted = {rem_ff[i-1][VW-2:0], 1'b0};

      always_ff @(posedge clock) begin
         dvs_ff[i]  <= dvs_ff[i-1];
         zero_ff[i] <= zero_ff[i-1];
         done_ff[i] <= done_ff[i-1];
         if (!done_ff[i-1] && shifted >= dvs_ff[i-1]) begin
            rem_ff[i] <= shifted - dvs_ff[i-1];
            q_ff[i]   <= {q_ff[i-1][FB-1:0], 1'b1};
         end else if (!done_ff[i-1]) begin
            rem_ff[i] <= shifted;
            q_ff[i]   <= {q_ff[i-1][FB-1:0], 1'b0};
         end else begin
            rem_ff[i] <= rem_ff[i-1];
            q_ff[i]   <= q_ff[i-1];
         end
      end
   end

   assign quo  = q_ff[FB];
   assign zero = zero_ff[FB];

endmodule
